/* rtl/dlac_pkg.sv */
// Shared types, codes and constants of the door lock actuator controller.
package dlac_pkg;

   localparam int TIME_WIDTH    = 16;
   localparam int PERIOD_WIDTH  = 8;
   localparam int STABLE_WIDTH  = 15;
   localparam int TIMEOUT_WIDTH = 16;
   localparam int STARTUP_WIDTH = 17;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [PERIOD_WIDTH-1:0]  SAMPLE_PERIOD_RESET     = 8'd10;
   localparam logic [STABLE_WIDTH-1:0]  STABLE_TIME_RESET       = 15'd100;
   localparam logic [TIMEOUT_WIDTH-1:0] OPERATION_TIMEOUT_RESET = 16'd1000;

   typedef enum logic [2:0] {
      OP_TICK       = 3'd0,
      OP_DOOR_QUERY = 3'd1,
      OP_LOCK_QUERY = 3'd2,
      OP_UNLOCK     = 3'd3,
      OP_LOCK       = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      KIND_NONE          = 3'd0,
      KIND_DOOR_STATUS   = 3'd1,
      KIND_LOCK_STATUS   = 3'd2,
      KIND_UNLOCK_RESULT = 3'd3,
      KIND_LOCK_RESULT   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      PEND_NONE   = 2'd0,
      PEND_UNLOCK = 2'd1,
      PEND_LOCK   = 2'd2
   } pend_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SAMPLE_PERIOD     = 2'd0,
      CSR_STABLE_TIME       = 2'd1,
      CSR_OPERATION_TIMEOUT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [2:0] op;
      logic       raw_lock;
      logic       raw_hole;
      logic       raw_door;
   } req_word_type;

   typedef struct packed {
      logic [2:0] reply_kind;
      logic       reply_value;
      logic       drive_open;
      logic       busy_res;
   } rsp_word_type;

   typedef struct packed {
      logic [PERIOD_WIDTH-1:0]  sample_period;
      logic [STABLE_WIDTH-1:0]  stable_time;
      logic [TIMEOUT_WIDTH-1:0] operation_timeout;
   } cfg_type;

   // Committed state of one sensor, before and after the current sample.
   typedef struct packed {
      logic committed;
      logic fresh;
   } sensor_status_type;

endpackage

/* rtl/door_lock_actuator_controller.sv */
// Top level of the door lock actuator controller: control core and ports.
//
//   Channel  Direction  Ports                                   Word
//   req      in         req_valid, req_stall, req_data          op and raw sensor bits
//   rsp      out        rsp_valid, rsp_stall, rsp_data          reply, drive, busy
//   csr      in         csr_write, csr_index, csr_data          register write
//
// Each word is captured in an input register and processed once the result
// queue has room, when it moves into the queue; a word can be accepted every
// cycle while req_stall is low.
// The result queue holds two words, which lets the input side keep moving while
// one result waits to be taken; req_stall rises only when the queue is full.
// Reset is synchronous and active high; it clears all sensor, timer and
// operation state and loads the register defaults.
module door_lock_actuator_controller (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  dlac_pkg::req_word_type                   req_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output dlac_pkg::rsp_word_type                   rsp_data,
   input  logic                                     csr_write,
   input  logic [dlac_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [dlac_pkg::CSR_DATA_WIDTH-1:0]      csr_data
);

   // Configuration registers.
   dlac_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_period     <= dlac_pkg::SAMPLE_PERIOD_RESET;
         cfg_ff.stable_time       <= dlac_pkg::STABLE_TIME_RESET;
         cfg_ff.operation_timeout <= dlac_pkg::OPERATION_TIMEOUT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            dlac_pkg::CSR_SAMPLE_PERIOD: begin
               cfg_ff.sample_period <= csr_data[dlac_pkg::PERIOD_WIDTH-1:0];
            end
            dlac_pkg::CSR_STABLE_TIME: begin
               cfg_ff.stable_time <= csr_data[dlac_pkg::STABLE_WIDTH-1:0];
            end
            dlac_pkg::CSR_OPERATION_TIMEOUT: begin
               cfg_ff.operation_timeout <= csr_data[dlac_pkg::TIMEOUT_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Input register. It holds its word while the result queue is full.
   logic                   s1_valid_ff;
   dlac_pkg::req_word_type s1_data_ff;
   logic                   q_space;
   logic                   advance;

   assign req_stall = s1_valid_ff && !q_space;
   assign advance   = s1_valid_ff && q_space;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_data_ff <= req_data;
      end
   end

   // Sample prescaler: a tick that brings the count to the period samples.
   logic [dlac_pkg::PERIOD_WIDTH-1:0] prescale_ff, prescale_in;
   logic [dlac_pkg::PERIOD_WIDTH-1:0] prescale_inc;
   logic                              is_tick;
   logic                              sample_en;

   assign is_tick      = advance && (s1_data_ff.op == dlac_pkg::OP_TICK);
   assign prescale_inc = prescale_ff + 1'b1;
   assign sample_en    = is_tick && (prescale_inc >= cfg_ff.sample_period);

   always_comb begin
      prescale_in = prescale_ff;
      if (is_tick) begin
         prescale_in = sample_en ? '0 : prescale_inc;
      end
   end

   dlac_pkg::sensor_status_type lock_st, hole_st, door_st;

   dlac_debounce u_lock (
      .clock     (clock),
      .reset     (reset),
      .sample_en (sample_en),
      .raw       (s1_data_ff.raw_lock),
      .cfg       (cfg_ff),
      .status    (lock_st)
   );

   dlac_debounce u_hole (
      .clock     (clock),
      .reset     (reset),
      .sample_en (sample_en),
      .raw       (s1_data_ff.raw_hole),
      .cfg       (cfg_ff),
      .status    (hole_st)
   );

   dlac_debounce u_door (
      .clock     (clock),
      .reset     (reset),
      .sample_en (sample_en),
      .raw       (s1_data_ff.raw_door),
      .cfg       (cfg_ff),
      .status    (door_st)
   );

   // Operation and power-on state.
   dlac_pkg::pend_type                  pending_ff, pending_in;
   logic [dlac_pkg::TIMEOUT_WIDTH-1:0]  countdown_ff, countdown_in;
   logic [dlac_pkg::TIMEOUT_WIDTH-1:0]  countdown_dec;
   logic                                drive_ff, drive_in;
   logic [dlac_pkg::STARTUP_WIDTH-1:0]  startup_ff, startup_in;
   logic [dlac_pkg::STARTUP_WIDTH-1:0]  startup_limit;
   logic                                startup_done_ff, startup_done_in;
   logic                                tick_confirm;
   logic                                req_confirm_unlock;
   logic                                req_confirm_lock;
   dlac_pkg::rsp_word_type              rsp_in;

   assign countdown_dec = countdown_ff - 1'b1;
   assign startup_limit = {1'b0, cfg_ff.stable_time, 1'b0};

   // Confirmation on a tick looks at the freshly debounced states.
   always_comb begin
      if (pending_ff == dlac_pkg::PEND_UNLOCK) begin
         tick_confirm = lock_st.fresh && hole_st.fresh;
      end else begin
         tick_confirm = !lock_st.fresh && !hole_st.fresh && !door_st.fresh;
      end
   end

   assign req_confirm_unlock = lock_st.committed && hole_st.committed;
   assign req_confirm_lock   = !lock_st.committed && !hole_st.committed
                               && !door_st.committed;

   always_comb begin
      pending_in      = pending_ff;
      countdown_in    = countdown_ff;
      drive_in        = drive_ff;
      startup_in      = startup_ff;
      startup_done_in = startup_done_ff;
      rsp_in.reply_kind  = dlac_pkg::KIND_NONE;
      rsp_in.reply_value = 1'b0;

      if (advance) begin
         case (s1_data_ff.op)
            dlac_pkg::OP_TICK: begin
               // Power-on check: an open door opens the lock once, unless an
               // operation is already under way.
               if (!startup_done_ff) begin
                  startup_in = startup_ff + 1'b1;
                  if (startup_in >= startup_limit) begin
                     startup_done_in = 1'b1;
                     if (door_st.fresh && (pending_ff == dlac_pkg::PEND_NONE)) begin
                        drive_in = 1'b1;
                     end
                  end
               end
               if (pending_ff != dlac_pkg::PEND_NONE) begin
                  countdown_in = countdown_dec;
                  if (countdown_dec == '0) begin
                     // Timeout: report failure and reverse the drive.
                     rsp_in.reply_kind = (pending_ff == dlac_pkg::PEND_UNLOCK)
                                         ? dlac_pkg::KIND_UNLOCK_RESULT
                                         : dlac_pkg::KIND_LOCK_RESULT;
                     drive_in   = (pending_ff != dlac_pkg::PEND_UNLOCK);
                     pending_in = dlac_pkg::PEND_NONE;
                  end else if (tick_confirm) begin
                     rsp_in.reply_kind = (pending_ff == dlac_pkg::PEND_UNLOCK)
                                         ? dlac_pkg::KIND_UNLOCK_RESULT
                                         : dlac_pkg::KIND_LOCK_RESULT;
                     rsp_in.reply_value = 1'b1;
                     pending_in         = dlac_pkg::PEND_NONE;
                  end
               end
            end
            dlac_pkg::OP_DOOR_QUERY: begin
               rsp_in.reply_kind  = dlac_pkg::KIND_DOOR_STATUS;
               rsp_in.reply_value = door_st.committed;
            end
            dlac_pkg::OP_LOCK_QUERY: begin
               rsp_in.reply_kind  = dlac_pkg::KIND_LOCK_STATUS;
               rsp_in.reply_value = lock_st.committed;
            end
            dlac_pkg::OP_UNLOCK: begin
               // A request while another operation waits is dropped.
               if (pending_ff == dlac_pkg::PEND_NONE) begin
                  drive_in = 1'b1;
                  if (cfg_ff.operation_timeout == '0) begin
                     rsp_in.reply_kind = dlac_pkg::KIND_UNLOCK_RESULT;
                     drive_in          = 1'b0;
                  end else if (req_confirm_unlock) begin
                     rsp_in.reply_kind  = dlac_pkg::KIND_UNLOCK_RESULT;
                     rsp_in.reply_value = 1'b1;
                  end else begin
                     pending_in   = dlac_pkg::PEND_UNLOCK;
                     countdown_in = cfg_ff.operation_timeout;
                  end
               end
            end
            dlac_pkg::OP_LOCK: begin
               if (pending_ff == dlac_pkg::PEND_NONE) begin
                  drive_in = 1'b0;
                  if (cfg_ff.operation_timeout == '0) begin
                     rsp_in.reply_kind = dlac_pkg::KIND_LOCK_RESULT;
                     drive_in          = 1'b1;
                  end else if (req_confirm_lock) begin
                     rsp_in.reply_kind  = dlac_pkg::KIND_LOCK_RESULT;
                     rsp_in.reply_value = 1'b1;
                  end else begin
                     pending_in   = dlac_pkg::PEND_LOCK;
                     countdown_in = cfg_ff.operation_timeout;
                  end
               end
            end
            default: begin
               // Unknown operations leave everything as it is.
            end
         endcase
      end

      rsp_in.drive_open = drive_in;
      rsp_in.busy_res   = (pending_in != dlac_pkg::PEND_NONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff     <= '0;
         pending_ff      <= dlac_pkg::PEND_NONE;
         countdown_ff    <= '0;
         drive_ff        <= 1'b0;
         startup_ff      <= '0;
         startup_done_ff <= 1'b0;
      end else begin
         prescale_ff     <= prescale_in;
         pending_ff      <= pending_in;
         countdown_ff    <= countdown_in;
         drive_ff        <= drive_in;
         startup_ff      <= startup_in;
         startup_done_ff <= startup_done_in;
      end
   end

   dlac_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (advance),
      .wr_data   (rsp_in),
      .space     (q_space),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // A waiting operation always has ticks left on its countdown.
   a_pending_countdown: assert property (@(posedge clock) disable iff (reset)
      (pending_ff != dlac_pkg::PEND_NONE) |-> (countdown_ff != '0))
      else $error("operation pending with an expired countdown");

   // An unlock or lock result always ends the operation.
   a_result_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && ((rsp_in.reply_kind == dlac_pkg::KIND_UNLOCK_RESULT)
                   || (rsp_in.reply_kind == dlac_pkg::KIND_LOCK_RESULT)))
      |=> (pending_ff == dlac_pkg::PEND_NONE))
      else $error("operation still pending after its result");

   // The input side stalls only while the result queue is full.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && !q_space))
      else $error("input stalled with room in the result queue");

   // The drive reported with a word matches the drive register after it.
   a_drive_match: assert property (@(posedge clock) disable iff (reset)
      advance |=> (drive_ff == $past(rsp_in.drive_open)))
      else $error("reported drive differs from actuator drive");

endmodule

/* rtl/dlac_debounce.sv */
// Debounce filter for one sensor: settle timer and committed state.
module dlac_debounce (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        sample_en,
   input  logic                        raw,
   input  dlac_pkg::cfg_type           cfg,
   output dlac_pkg::sensor_status_type status
);

   logic                           state_ff, state_in;
   logic [dlac_pkg::TIME_WIDTH-1:0] settle_ff, settle_in;
   logic [dlac_pkg::TIME_WIDTH:0]   sum;
   logic [dlac_pkg::TIME_WIDTH-1:0] sat;

   always_comb begin
      sum = {1'b0, settle_ff}
            + (dlac_pkg::TIME_WIDTH+1)'(cfg.sample_period);
      sat = sum[dlac_pkg::TIME_WIDTH] ? {dlac_pkg::TIME_WIDTH{1'b1}}
                                      : sum[dlac_pkg::TIME_WIDTH-1:0];
      state_in  = state_ff;
      settle_in = settle_ff;
      if (sample_en) begin
         if (raw != state_ff) begin
            if (sat >= dlac_pkg::TIME_WIDTH'(cfg.stable_time)) begin
               settle_in = '0;
               state_in  = raw;
            end else begin
               settle_in = sat;
            end
         end else begin
            settle_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= 1'b0;
         settle_ff <= '0;
      end else begin
         state_ff  <= state_in;
         settle_ff <= settle_in;
      end
   end

   assign status.committed = state_ff;
   assign status.fresh     = state_in;

endmodule

/* rtl/dlac_rsp_queue.sv */
// Two-entry result queue that decouples the result channel from the core.
module dlac_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  dlac_pkg::rsp_word_type wr_data,
   output logic                   space,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dlac_pkg::rsp_word_type rsp_data
);

   dlac_pkg::rsp_word_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       rd_en;

   assign space     = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign rd_en     = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ wr_en;
      rd_ptr_in = rd_ptr_ff ^ rd_en;
      count_in  = count_ff + {1'b0, wr_en} - {1'b0, rd_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* tb/sv/door_lock_actuator_controller_tb.sv */
// Self-checking testbench for the door lock actuator controller.
`timescale 1ns / 100ps

module door_lock_actuator_controller_tb;

   // Op codes past the last defined one; the block must ignore them.
   localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

   localparam int LONG_HOLD_CYCLES = 60;
   localparam int DRAIN_CYCLES     = 6;
   localparam int WATCHDOG_NS      = 2_000_000;

   // Scoreboard: keeps its own copy of the controller state, works out the
   // reply of every accepted request word and checks the replies in order.
   class lock_reply_board;
      logic [dlac_pkg::PERIOD_WIDTH-1:0]  period;
      logic [dlac_pkg::STABLE_WIDTH-1:0]  stable;
      logic [dlac_pkg::TIMEOUT_WIDTH-1:0] timeout;

      logic                               lock_seen, hole_seen, door_seen;
      logic [dlac_pkg::TIME_WIDTH-1:0]    lock_age, hole_age, door_age;
      logic [dlac_pkg::PERIOD_WIDTH-1:0]  sample_count;
      logic [dlac_pkg::TIMEOUT_WIDTH-1:0] ticks_left;
      dlac_pkg::pend_type                 waiting_for;
      logic                               drive_cmd;
      logic [dlac_pkg::STARTUP_WIDTH-1:0] power_on_count;
      logic                               power_on_over;

      dlac_pkg::rsp_word_type expected_q[$];
      int errors, n_words, n_status, n_confirmed, n_failed, n_dropped, n_ignored;

      function new();
         period = dlac_pkg::SAMPLE_PERIOD_RESET;
         stable = dlac_pkg::STABLE_TIME_RESET;
         timeout = dlac_pkg::OPERATION_TIMEOUT_RESET;
         lock_seen = 1'b0;
         hole_seen = 1'b0;
         door_seen = 1'b0;
         lock_age = '0;
         hole_age = '0;
         door_age = '0;
         sample_count = '0;
         ticks_left = '0;
         waiting_for = dlac_pkg::PEND_NONE;
         drive_cmd = 1'b0;
         power_on_count = '0;
         power_on_over = 1'b0;
         errors = 0;
         n_words = 0;
         n_status = 0;
         n_confirmed = 0;
         n_failed = 0;
         n_dropped = 0;
         n_ignored = 0;
      endfunction

      function void write_register(dlac_pkg::csr_index_type idx,
                                   logic [dlac_pkg::CSR_DATA_WIDTH-1:0] value);
         case (idx)
            dlac_pkg::CSR_SAMPLE_PERIOD:
               period = value[dlac_pkg::PERIOD_WIDTH-1:0];
            dlac_pkg::CSR_STABLE_TIME:
               stable = value[dlac_pkg::STABLE_WIDTH-1:0];
            dlac_pkg::CSR_OPERATION_TIMEOUT:
               timeout = value[dlac_pkg::TIMEOUT_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      // One debounce sample: a differing reading ages the sensor, a matching
      // one clears its age, and reaching the stable time commits the reading.
      function void age_sensor(input logic raw, inout logic seen,
                               inout logic [dlac_pkg::TIME_WIDTH-1:0] age);
         logic [dlac_pkg::TIME_WIDTH:0] sum;
         if (raw != seen) begin
            sum = {1'b0, age} + period;
            if (sum[dlac_pkg::TIME_WIDTH]) sum = {1'b0, {dlac_pkg::TIME_WIDTH{1'b1}}};
            if (sum >= stable) begin
               sum = '0;
               seen = raw;
            end
            age = sum[dlac_pkg::TIME_WIDTH-1:0];
         end else begin
            age = '0;
         end
      endfunction

      function bit holds(dlac_pkg::pend_type p);
         if (p == dlac_pkg::PEND_UNLOCK) return lock_seen && hole_seen;
         return !lock_seen && !hole_seen && !door_seen;
      endfunction

      function void note_request(dlac_pkg::req_word_type w);
         dlac_pkg::rsp_word_type r;
         dlac_pkg::kind_type     k;
         logic                   v;
         dlac_pkg::pend_type     p;
         k = dlac_pkg::KIND_NONE;
         v = 1'b0;
         n_words++;
         case (w.op)
            dlac_pkg::OP_TICK: begin
               sample_count = sample_count + 1'b1;
               if (sample_count >= period) begin
                  sample_count = '0;
                  age_sensor(w.raw_lock, lock_seen, lock_age);
                  age_sensor(w.raw_hole, hole_seen, hole_age);
                  age_sensor(w.raw_door, door_seen, door_age);
               end
               if (!power_on_over) begin
                  power_on_count = power_on_count + 1'b1;
                  // The power-on delay is twice the stable time.
                  if (power_on_count >= {1'b0, stable, 1'b0}) begin
                     power_on_over = 1'b1;
                     if (door_seen && waiting_for == dlac_pkg::PEND_NONE) drive_cmd = 1'b1;
                  end
               end
               if (waiting_for != dlac_pkg::PEND_NONE) begin
                  ticks_left = ticks_left - 1'b1;
                  if (waiting_for == dlac_pkg::PEND_UNLOCK) k = dlac_pkg::KIND_UNLOCK_RESULT;
                  else k = dlac_pkg::KIND_LOCK_RESULT;
                  if (ticks_left == '0) begin
                     drive_cmd = (waiting_for == dlac_pkg::PEND_LOCK);
                     waiting_for = dlac_pkg::PEND_NONE;
                     n_failed++;
                  end else if (holds(waiting_for)) begin
                     v = 1'b1;
                     waiting_for = dlac_pkg::PEND_NONE;
                     n_confirmed++;
                  end else begin
                     k = dlac_pkg::KIND_NONE;
                  end
               end
            end
            dlac_pkg::OP_DOOR_QUERY: begin
               k = dlac_pkg::KIND_DOOR_STATUS;
               v = door_seen;
               n_status++;
            end
            dlac_pkg::OP_LOCK_QUERY: begin
               k = dlac_pkg::KIND_LOCK_STATUS;
               v = lock_seen;
               n_status++;
            end
            dlac_pkg::OP_UNLOCK, dlac_pkg::OP_LOCK: begin
               if (waiting_for != dlac_pkg::PEND_NONE) begin
                  n_dropped++;
               end else begin
                  if (w.op == dlac_pkg::OP_UNLOCK) begin
                     p = dlac_pkg::PEND_UNLOCK;
                     k = dlac_pkg::KIND_UNLOCK_RESULT;
                  end else begin
                     p = dlac_pkg::PEND_LOCK;
                     k = dlac_pkg::KIND_LOCK_RESULT;
                  end
                  drive_cmd = (p == dlac_pkg::PEND_UNLOCK);
                  if (timeout == '0) begin
                     drive_cmd = ~drive_cmd;
                     n_failed++;
                  end else if (holds(p)) begin
                     v = 1'b1;
                     n_confirmed++;
                  end else begin
                     k = dlac_pkg::KIND_NONE;
                     waiting_for = p;
                     ticks_left = timeout;
                  end
               end
            end
            default: n_ignored++;
         endcase
         r.reply_kind = k;
         r.reply_value = v;
         r.drive_open = drive_cmd;
         r.busy_res = (waiting_for != dlac_pkg::PEND_NONE);
         expected_q.push_back(r);
      endfunction

      function void check_reply(dlac_pkg::rsp_word_type got);
         dlac_pkg::rsp_word_type want;
         if (expected_q.size() == 0) begin
            $error("reply word %0h arrived with no request outstanding", got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.reply_kind !== want.reply_kind) begin
            $error("reply_kind: expected %0d, got %0d", want.reply_kind, got.reply_kind);
            errors++;
         end
         if (got.reply_value !== want.reply_value) begin
            $error("reply_value: expected %0d, got %0d", want.reply_value, got.reply_value);
            errors++;
         end
         if (got.drive_open !== want.drive_open) begin
            $error("drive_open: expected %0d, got %0d", want.drive_open, got.drive_open);
            errors++;
         end
         if (got.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
            errors++;
         end
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction
   endclass

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   dlac_pkg::req_word_type                req_data;
   logic                                  rsp_valid;
   logic                                  rsp_stall;
   dlac_pkg::rsp_word_type                rsp_data;
   logic                                  csr_write;
   logic [dlac_pkg::CSR_INDEX_WIDTH-1:0]  csr_index;
   logic [dlac_pkg::CSR_DATA_WIDTH-1:0]   csr_data;

   lock_reply_board board = new();

   // Both sides idle at random unless quiet is set; a change of hold_requests
   // asks the reply side for one long hold-off.
   bit quiet;
   int hold_requests;
   int holds_done;
   int settings_used;

   door_lock_actuator_controller u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Mostly back-to-back, sometimes a short pause, now and then a long one.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   function automatic dlac_pkg::req_word_type make_word(logic [2:0] op, bit l, bit h, bit d);
      dlac_pkg::req_word_type w;
      w.op = op;
      w.raw_lock = l;
      w.raw_hole = h;
      w.raw_door = d;
      return w;
   endfunction

   function automatic bit coin();
      return $urandom_range(0, 1);
   endfunction

   // Offers one request word and returns once the block has taken it.
   task automatic send_word(input dlac_pkg::req_word_type w, input bit eager);
      int gap;
      gap = (eager || quiet) ? 0 : gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(w);
   endtask

   task automatic send_tick(input bit l, input bit h, input bit d);
      send_word(make_word(dlac_pkg::OP_TICK, l, h, d), 1'b0);
   endtask

   task automatic send_op(input logic [2:0] op);
      send_word(make_word(op, coin(), coin(), coin()), 1'b0);
   endtask

   // Stops offering words and waits until every reply has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers on consecutive edges; only called when idle.
   task automatic set_config(input logic [dlac_pkg::CSR_DATA_WIDTH-1:0] period,
                             input logic [dlac_pkg::CSR_DATA_WIDTH-1:0] stable,
                             input logic [dlac_pkg::CSR_DATA_WIDTH-1:0] timeout);
      csr_write <= 1'b1;
      csr_index <= dlac_pkg::CSR_SAMPLE_PERIOD;
      csr_data <= period;
      @(posedge clock);
      board.write_register(dlac_pkg::CSR_SAMPLE_PERIOD, period);
      csr_index <= dlac_pkg::CSR_STABLE_TIME;
      csr_data <= stable;
      @(posedge clock);
      board.write_register(dlac_pkg::CSR_STABLE_TIME, stable);
      csr_index <= dlac_pkg::CSR_OPERATION_TIMEOUT;
      csr_data <= timeout;
      @(posedge clock);
      board.write_register(dlac_pkg::CSR_OPERATION_TIMEOUT, timeout);
      csr_write <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   // Hand-picked sequence with period 1, stable time 1 and timeout 3, so that
   // every sensor change commits on its first tick and power-on ends on the
   // second tick.
   task automatic run_directed();
      bit start_busy;
      // Power-on completes only once per run, so a coin decides whether it
      // lands on a pending unlock or on an idle block with the door open.
      start_busy = coin();
      send_op(dlac_pkg::OP_LOCK_QUERY);
      if (start_busy) send_op(dlac_pkg::OP_UNLOCK);
      else send_op(dlac_pkg::OP_DOOR_QUERY);
      send_tick(1'b0, 1'b0, 1'b1);
      send_tick(1'b0, 1'b0, 1'b1);
      send_op(dlac_pkg::OP_UNLOCK);
      send_op(dlac_pkg::OP_LOCK);
      send_op(dlac_pkg::OP_DOOR_QUERY);
      // Lock and hole stay closed, so the unlock runs out of time.
      repeat (3) send_tick(1'b0, 1'b0, 1'b1);
      for (int k = OP_FIRST_UNUSED; k <= OP_LAST_UNUSED; k++) send_op(3'(k));
      send_tick(1'b1, 1'b1, 1'b1);
      // Lock and hole already read open: the unlock succeeds at once.
      send_op(dlac_pkg::OP_UNLOCK);
      send_op(dlac_pkg::OP_LOCK_QUERY);
      send_op(dlac_pkg::OP_LOCK);
      send_tick(1'b0, 1'b0, 1'b0);
      send_op(dlac_pkg::OP_LOCK);
      send_op(dlac_pkg::OP_UNLOCK);
      send_tick(1'b1, 1'b1, 1'b0);
      // An open door keeps the lock from being confirmed.
      send_op(dlac_pkg::OP_LOCK);
      repeat (3) send_tick(1'b0, 1'b0, 1'b1);
   endtask

   // Random traffic. Most stretches open with an unlock or lock request and
   // then feed ticks whose sensors move toward the state that confirms it,
   // with a little noise, queries and stray requests mixed in. The rest are
   // stretches of arbitrary words.
   task automatic run_random(input int count, input bit eager);
      int left;
      int len;
      int r;
      bit orderly;
      bit goal_unlock;
      bit want_l, want_h, want_d;
      left = count;
      while (left > 0) begin
         orderly = ($urandom_range(0, 9) < 8);
         goal_unlock = coin();
         want_l = goal_unlock;
         want_h = goal_unlock;
         want_d = goal_unlock ? coin() : 1'b0;
         if (orderly) begin
            if (goal_unlock) begin
               send_word(make_word(dlac_pkg::OP_UNLOCK, coin(), coin(), coin()), eager);
            end else begin
               send_word(make_word(dlac_pkg::OP_LOCK, coin(), coin(), coin()), eager);
            end
            left--;
         end
         len = $urandom_range(3, 25);
         repeat (len) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
               if (coin()) begin
                  send_word(make_word(dlac_pkg::OP_DOOR_QUERY, coin(), coin(), coin()),
                            eager);
               end else begin
                  send_word(make_word(dlac_pkg::OP_LOCK_QUERY, coin(), coin(), coin()),
                            eager);
               end
               left--;
            end else if (r < 12) begin
               if (coin()) begin
                  send_word(make_word(dlac_pkg::OP_UNLOCK, coin(), coin(), coin()), eager);
               end else begin
                  send_word(make_word(dlac_pkg::OP_LOCK, coin(), coin(), coin()), eager);
               end
               left--;
            end else if (r < 14) begin
               // Unused codes are ignored and are not counted.
               send_word(make_word(3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)),
                                   coin(), coin(), coin()), eager);
            end else if (orderly) begin
               send_word(make_word(dlac_pkg::OP_TICK,
                                   want_l ^ ($urandom_range(0, 9) == 0),
                                   want_h ^ ($urandom_range(0, 9) == 0),
                                   want_d ^ ($urandom_range(0, 9) == 0)), eager);
               left--;
            end else begin
               send_word(make_word(dlac_pkg::OP_TICK, coin(), coin(), coin()), eager);
               left--;
            end
         end
      end
   endtask

   // Reply side: random hold-offs, plus one long hold-off on request.
   initial begin : reply_stall_driver
      int n;
      forever begin
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (quiet) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            n = gap_length();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // Every reply word taken off the channel goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_reply(rsp_data);
   end

   initial begin : watchdog
      #(WATCHDOG_NS);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : main_sequence
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_write <= 1'b0;
      csr_index <= dlac_pkg::CSR_SAMPLE_PERIOD;
      csr_data <= '0;
      quiet <= 1'b0;
      hold_requests <= 0;
      settings_used = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_config(16'd1, 16'd1, 16'd3);
      run_directed();
      drain();

      // A stretch with no idling on either side, then normal traffic.
      set_config(16'd2, 16'd6, 16'd20);
      quiet <= 1'b1;
      run_random(40, 1'b0);
      quiet <= 1'b0;
      run_random(80, 1'b0);
      drain();

      // The reply side holds off for a long time while words keep coming,
      // so the block fills up and stalls its input.
      set_config(16'd1, 16'd3, 16'd8);
      run_random(50, 1'b0);
      hold_requests <= hold_requests + 1;
      run_random(30, 1'b1);
      run_random(40, 1'b0);
      drain();

      // Mid-phase pause until every reply is back.
      set_config(16'd3, 16'd10, 16'd40);
      run_random(50, 1'b0);
      drain();
      run_random(50, 1'b0);
      drain();

      // Largest register values, then the smallest nonzero ones.
      set_config(16'd255, 16'd32767, 16'd65535);
      run_random(30, 1'b0);
      drain();
      set_config(16'd1, 16'd1, 16'd1);
      run_random(40, 1'b0);
      drain();

      // Zero sample period with zero timeout: nothing commits and every
      // request fails at once. Then zero stable time commits on every sample.
      set_config(16'd0, 16'd5, 16'd0);
      run_random(25, 1'b0);
      drain();
      set_config(16'd0, 16'd0, 16'd10);
      run_random(30, 1'b0);
      drain();

      set_config(16'($urandom_range(1, 4)), 16'($urandom_range(1, 16)),
                 16'($urandom_range(4, 50)));
      run_random(80, 1'b0);
      drain();

      $display("Ran %0d words under %0d register settings: %0d status replies, %0d confirmed,",
               board.n_words, settings_used, board.n_status, board.n_confirmed);
      $display("%0d failed operations, %0d dropped requests and %0d ignored words.",
               board.n_failed, board.n_dropped, board.n_ignored);
      if (board.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
